@@ rtl/hhed_pkg.sv @@
// ----------------------------------------------------------------------------
// hhed_pkg
// Shared types and constants for the http header end detector: character
// codes, byte classes, status codes and the queue entry format.
// ----------------------------------------------------------------------------
package hhed_pkg;

    // characters the parser cares about
    localparam logic [7:0] CH_SP  = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // byte classes produced by the front end
    typedef logic [1:0] byte_class_t;
    localparam byte_class_t CLS_OTHER = 2'd0;
    localparam byte_class_t CLS_BLANK = 2'd1;
    localparam byte_class_t CLS_LF    = 2'd2;
    localparam byte_class_t CLS_CR    = 2'd3;

    // header status codes
    typedef logic [1:0] status_t;
    localparam status_t STAT_MORE = 2'd0;
    localparam status_t STAT_DONE = 2'd1;
    localparam status_t STAT_BAD  = 2'd2;

    // one classified byte as held in the queue
    typedef struct packed {
        logic        start;
        byte_class_t cls;
    } item_t;

    localparam int ITEM_W = $bits(item_t);

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

endpackage

@@ rtl/hhed_front.sv @@
// ----------------------------------------------------------------------------
// hhed_front
// Input side: accepts request bytes and reduces each one to a byte class
// together with its start-of-request flag, then hands it to the queue.
// ----------------------------------------------------------------------------
module hhed_front
(
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [7:0]      s_tdata,    // data_byte
    input  logic            s_tuser,    // start_of_request
    output logic            push_valid,
    input  logic            push_ready,
    output hhed_pkg::item_t push_data
);

    hhed_pkg::byte_class_t cls;

    // classify the byte
    always_comb
    begin
        if (s_tdata == hhed_pkg::CH_SP || s_tdata == hhed_pkg::CH_TAB)
        begin
            cls = hhed_pkg::CLS_BLANK;
        end
        else if (s_tdata == hhed_pkg::CH_LF)
        begin
            cls = hhed_pkg::CLS_LF;
        end
        else if (s_tdata == hhed_pkg::CH_CR)
        begin
            cls = hhed_pkg::CLS_CR;
        end
        else
        begin
            cls = hhed_pkg::CLS_OTHER;
        end
    end

    // pass the transfer on to the queue
    assign push_valid      = s_tvalid;
    assign s_tready        = push_ready;
    assign push_data.start = s_tuser;
    assign push_data.cls   = cls;

endmodule

@@ rtl/hhed_queue.sv @@
// ----------------------------------------------------------------------------
// hhed_queue
// Short first-in first-out queue of classified bytes between the front end
// and the parser, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module hhed_queue
#(
    parameter int DEPTH = hhed_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  hhed_pkg::item_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output hhed_pkg::item_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hhed_pkg::item_t    entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/hhed_back.sv @@
// ----------------------------------------------------------------------------
// hhed_back
// Parser: steps the request-line and header-end state machine on each
// classified byte and holds the resulting status in an output register.
// ----------------------------------------------------------------------------
module hhed_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  hhed_pkg::item_t pop_data,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata     // header_status, zero padded
);

    localparam logic [3:0] ST_WORD1  = 4'd0;
    localparam logic [3:0] ST_WS1    = 4'd1;
    localparam logic [3:0] ST_WORD2  = 4'd2;
    localparam logic [3:0] ST_WS2    = 4'd3;
    localparam logic [3:0] ST_WORD3  = 4'd4;
    localparam logic [3:0] ST_LINE   = 4'd5;
    localparam logic [3:0] ST_LF     = 4'd6;
    localparam logic [3:0] ST_CR     = 4'd7;
    localparam logic [3:0] ST_CRLF   = 4'd8;
    localparam logic [3:0] ST_CRLFCR = 4'd9;
    localparam logic [3:0] ST_BAD    = 4'd10;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [3:0]          cur;
    hhed_pkg::status_t   status;
    hhed_pkg::status_t   status_reg;
    logic                valid_reg;
    logic                valid_next;
    logic                take;
    logic                is_blank;
    logic                is_lf;
    logic                is_cr;
    logic                is_eol;

    // take a byte whenever the output register is free or being drained
    assign pop_ready = !valid_reg || m_tready;
    assign take      = pop_valid && pop_ready;

    assign is_blank = (pop_data.cls == hhed_pkg::CLS_BLANK);
    assign is_lf    = (pop_data.cls == hhed_pkg::CLS_LF);
    assign is_cr    = (pop_data.cls == hhed_pkg::CLS_CR);
    assign is_eol   = is_lf || is_cr;

    // next parse state and status for the byte at the queue head
    always_comb
    begin
        cur        = pop_data.start ? ST_WORD1 : state_reg;
        state_next = cur;
        status     = hhed_pkg::STAT_MORE;
        case (cur)
            ST_WORD1:
            begin
                if (is_blank)
                begin
                    state_next = ST_WS1;
                end
                else if (is_eol)
                begin
                    state_next = ST_BAD;
                    status     = hhed_pkg::STAT_BAD;
                end
            end
            ST_WS1, ST_WS2:
            begin
                if (is_eol)
                begin
                    state_next = ST_BAD;
                    status     = hhed_pkg::STAT_BAD;
                end
                else if (!is_blank)
                begin
                    state_next = (cur == ST_WS1) ? ST_WORD2 : ST_WORD3;
                end
            end
            ST_WORD2:
            begin
                if (is_blank)
                begin
                    state_next = ST_WS2;
                end
                else if (is_eol)
                begin
                    status = hhed_pkg::STAT_DONE;
                end
            end
            ST_WORD3, ST_LINE:
            begin
                if (is_blank && cur == ST_WORD3)
                begin
                    state_next = ST_BAD;
                    status     = hhed_pkg::STAT_BAD;
                end
                else if (is_lf)
                begin
                    state_next = ST_LF;
                end
                else if (is_cr)
                begin
                    state_next = ST_CR;
                end
            end
            ST_LF:
            begin
                if (is_lf)
                begin
                    status = hhed_pkg::STAT_DONE;
                end
                else if (is_cr)
                begin
                    state_next = ST_CR;
                end
                else
                begin
                    state_next = ST_LINE;
                end
            end
            ST_CR:
            begin
                if (is_lf)
                begin
                    state_next = ST_CRLF;
                end
                else if (is_cr)
                begin
                    status = hhed_pkg::STAT_DONE;
                end
                else
                begin
                    state_next = ST_LINE;
                end
            end
            ST_CRLF:
            begin
                if (is_lf)
                begin
                    status = hhed_pkg::STAT_DONE;
                end
                else if (is_cr)
                begin
                    state_next = ST_CRLFCR;
                end
                else
                begin
                    state_next = ST_LINE;
                end
            end
            ST_CRLFCR:
            begin
                if (is_eol)
                begin
                    status = hhed_pkg::STAT_DONE;
                end
                else
                begin
                    state_next = ST_LINE;
                end
            end
            default:
            begin
                // malformed, and any unused code, sticks
                status = hhed_pkg::STAT_BAD;
            end
        endcase
    end

    // output valid tracking
    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_WORD1;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                state_reg <= state_next;
            end
        end
    end

    // status payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            status_reg <= status;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, status_reg};

endmodule

@@ rtl/http_header_end_detector_top.sv @@
// ----------------------------------------------------------------------------
// http_header_end_detector_top
// Checks the request line of an http request and finds the end of its header.
// ----------------------------------------------------------------------------
// One request byte goes in per transfer and exactly one status comes out for
// each byte, in order: 0 need more bytes, 1 header complete, 2 malformed.
// The block sustains one byte per clock while the output side is not
// stalled; a byte's status passes through the queue entry written at the
// transfer and then the status register behind the parse state machine
// before it is offered on the output. Up to QUEUE_DEPTH classified bytes
// plus one held status are buffered while the output is stalled.
// start_of_request re-arms the parser at the first word before that byte.
// ----------------------------------------------------------------------------
module http_header_end_detector_top
#(
    parameter int QUEUE_DEPTH = hhed_pkg::QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // data_byte
    input  logic       s_tuser,     // start_of_request
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata      // header_status, upper bits zero
);

    logic            push_valid;
    logic            push_ready;
    hhed_pkg::item_t push_data;
    logic            pop_valid;
    logic            pop_ready;
    hhed_pkg::item_t pop_data;

    // byte classification
    hhed_front u_front
    (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    hhed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // parser and status output
    hhed_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ tb/http_header_end_detector_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_end_detector_top_tb
// Self-checking bench for the http header end detector. Request bytes are
// fed through the input stream while a parser model in the bench works out
// the status of every byte. Each output transfer is compared with the oldest
// status still due. A directed prologue covers the request line corner cases.
// It is followed by mostly well-formed random requests with some broken ones
// and some noise. Random gaps fall on both sides, and one long output stall
// backs the block up into its input.
// ----------------------------------------------------------------------------
module http_header_end_detector_top_tb;

    localparam int  NUM_ITEMS  = 1350;
    localparam int  HOLD_LEN   = 200;
    localparam int  HOLD_AT    = 400;
    localparam int  DRAIN      = 20;
    localparam int  MAX_CYCLES = 1000000;
    localparam int  MAX_REPORT = 10;

    // parser states
    localparam logic [3:0] PS_WORD1  = 4'd0;
    localparam logic [3:0] PS_WS1    = 4'd1;
    localparam logic [3:0] PS_WORD2  = 4'd2;
    localparam logic [3:0] PS_WS2    = 4'd3;
    localparam logic [3:0] PS_WORD3  = 4'd4;
    localparam logic [3:0] PS_LINE   = 4'd5;
    localparam logic [3:0] PS_LF     = 4'd6;
    localparam logic [3:0] PS_CR     = 4'd7;
    localparam logic [3:0] PS_CRLF   = 4'd8;
    localparam logic [3:0] PS_CRLFCR = 4'd9;
    localparam logic [3:0] PS_BAD    = 4'd10;

    // one request byte with its start flag
    typedef struct packed {
        logic       start;
        logic [7:0] data;
    } req_byte_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;     // data_byte
    logic       s_tuser;     // start_of_request
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;     // header_status, upper bits zero

    req_byte_t          req_bytes_q[$];
    hhed_pkg::status_t  status_due_q[$];
    logic [3:0]         parse_st = PS_WORD1;
    logic               next_start;

    int         in_gap;
    int         out_stall;
    int         bytes_in;
    int         fail_cnt;
    int         cycle_cnt = 0;
    int         hold_cycles;
    logic       hold_off;
    logic       hold_done;
    logic       quiet;

    http_header_end_detector_top DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock and reset
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return (c == hhed_pkg::CH_SP) || (c == hhed_pkg::CH_TAB);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == hhed_pkg::CH_LF) || (c == hhed_pkg::CH_CR);
    endfunction

    // parser model: advances parse_st by one byte, returns its status
    function automatic hhed_pkg::status_t parse_byte(input logic [7:0] c, input logic start);
        hhed_pkg::status_t stat;
        logic [3:0]        nxt;
        if (start)
            parse_st = PS_WORD1;
        nxt  = parse_st;
        stat = hhed_pkg::STAT_MORE;
        case (parse_st)
            PS_WORD1:
            begin
                if (is_blank(c))
                    nxt = PS_WS1;
                else if (is_eol(c))
                begin
                    nxt  = PS_BAD;
                    stat = hhed_pkg::STAT_BAD;
                end
            end
            PS_WS1, PS_WS2:
            begin
                if (is_eol(c))
                begin
                    nxt  = PS_BAD;
                    stat = hhed_pkg::STAT_BAD;
                end
                else if (!is_blank(c))
                    nxt = (parse_st == PS_WS1) ? PS_WORD2 : PS_WORD3;
            end
            PS_WORD2:
            begin
                if (is_blank(c))
                    nxt = PS_WS2;
                else if (is_eol(c))
                    stat = hhed_pkg::STAT_DONE;
            end
            PS_WORD3:
            begin
                if (is_blank(c))
                begin
                    nxt  = PS_BAD;
                    stat = hhed_pkg::STAT_BAD;
                end
                else if (c == hhed_pkg::CH_LF)
                    nxt = PS_LF;
                else if (c == hhed_pkg::CH_CR)
                    nxt = PS_CR;
            end
            PS_LINE:
            begin
                if (c == hhed_pkg::CH_LF)
                    nxt = PS_LF;
                else if (c == hhed_pkg::CH_CR)
                    nxt = PS_CR;
            end
            PS_LF:
            begin
                if (c == hhed_pkg::CH_LF)
                    stat = hhed_pkg::STAT_DONE;
                else if (c == hhed_pkg::CH_CR)
                    nxt = PS_CR;
                else
                    nxt = PS_LINE;
            end
            PS_CR:
            begin
                if (c == hhed_pkg::CH_LF)
                    nxt = PS_CRLF;
                else if (c == hhed_pkg::CH_CR)
                    stat = hhed_pkg::STAT_DONE;
                else
                    nxt = PS_LINE;
            end
            PS_CRLF:
            begin
                if (c == hhed_pkg::CH_LF)
                    stat = hhed_pkg::STAT_DONE;
                else if (c == hhed_pkg::CH_CR)
                    nxt = PS_CRLFCR;
                else
                    nxt = PS_LINE;
            end
            PS_CRLFCR:
            begin
                if (is_eol(c))
                    stat = hhed_pkg::STAT_DONE;
                else
                    nxt = PS_LINE;
            end
            // malformed and unused codes
            default:
                stat = hhed_pkg::STAT_BAD;
        endcase
        parse_st = nxt;
        return stat;
    endfunction

    // gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] c);
        req_bytes_q.push_back('{start: next_start, data: c});
        next_start = 1'b0;
    endtask

    task automatic add_word(input int nmin, input int nmax, input logic allow_blank);
        logic [7:0] c;
        int         n;
        n = $urandom_range(nmin, nmax);
        repeat (n)
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (is_eol(c) || (!allow_blank && is_blank(c)));
            add_byte(c);
        end
    endtask

    task automatic add_blanks(input int nmax);
        int n;
        n = $urandom_range(1, nmax);
        repeat (n)
            add_byte($urandom_range(0, 1) ? hhed_pkg::CH_SP : hhed_pkg::CH_TAB);
    endtask

    task automatic add_eol();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0)
            add_byte(hhed_pkg::CH_LF);
        else if (r == 1)
            add_byte(hhed_pkg::CH_CR);
        else
        begin
            add_byte(hhed_pkg::CH_CR);
            add_byte(hhed_pkg::CH_LF);
        end
    endtask

    // header terminator: one of the five blank-line forms
    task automatic add_terminator();
        case ($urandom_range(0, 4))
            0:
            begin
                add_byte(hhed_pkg::CH_LF);
                add_byte(hhed_pkg::CH_LF);
            end
            1:
            begin
                add_byte(hhed_pkg::CH_CR);
                add_byte(hhed_pkg::CH_CR);
            end
            2:
            begin
                add_byte(hhed_pkg::CH_CR);
                add_byte(hhed_pkg::CH_LF);
                add_byte(hhed_pkg::CH_LF);
            end
            3:
            begin
                add_byte(hhed_pkg::CH_CR);
                add_byte(hhed_pkg::CH_LF);
                add_byte(hhed_pkg::CH_CR);
                add_byte(hhed_pkg::CH_CR);
            end
            default:
            begin
                add_byte(hhed_pkg::CH_CR);
                add_byte(hhed_pkg::CH_LF);
                add_byte(hhed_pkg::CH_CR);
                add_byte(hhed_pkg::CH_LF);
            end
        endcase
    endtask

    task automatic add_request();
        int kind;
        int lines;
        kind       = $urandom_range(0, 99);
        next_start = 1'b1;
        add_word(1, 4, 1'b0);
        if (kind < 5)
        begin
            // early line end inside the request line
            if ($urandom_range(0, 1))
                add_blanks(2);
            if ($urandom_range(0, 1))
            begin
                add_word(1, 3, 1'b0);
                add_blanks(2);
            end
            add_byte($urandom_range(0, 1) ? hhed_pkg::CH_LF : hhed_pkg::CH_CR);
            add_word(0, 4, 1'b1);
            return;
        end
        add_blanks(3);
        add_word(1, 6, 1'b0);
        if (kind < 12)
        begin
            // two-word request, complete at the line end
            add_byte($urandom_range(0, 1) ? hhed_pkg::CH_LF : hhed_pkg::CH_CR);
            add_word(0, 2, 1'b1);
            return;
        end
        add_blanks(3);
        add_word(1, 6, 1'b0);
        if (kind < 17)
        begin
            // blank inside the third word
            add_blanks(2);
            add_word(0, 4, 1'b1);
            return;
        end
        lines = $urandom_range(0, 3);
        repeat (lines)
        begin
            add_eol();
            add_word(1, 8, 1'b1);
        end
        add_terminator();
        // trailing bytes after completion
        if ($urandom_range(0, 4) == 0)
        begin
            add_byte($urandom_range(0, 1) ? hhed_pkg::CH_LF : hhed_pkg::CH_CR);
            add_word(0, 3, 1'b1);
        end
    endtask

    task automatic add_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            next_start = ($urandom_range(0, 3) == 0);
            add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic add_directed();
        // full request with byte extremes, space and tab, lf lf terminator
        next_start = 1'b1;
        add_byte(8'h00);
        add_byte(hhed_pkg::CH_SP);
        add_byte(8'hFF);
        add_byte(hhed_pkg::CH_TAB);
        add_byte("H");
        add_byte(hhed_pkg::CH_LF);
        add_byte(hhed_pkg::CH_LF);
        // two-word request ends at cr, a second cr completes again
        next_start = 1'b1;
        add_byte("A");
        add_byte(hhed_pkg::CH_SP);
        add_byte("B");
        add_byte(hhed_pkg::CH_CR);
        add_byte(hhed_pkg::CH_CR);
        // line end in the first word, then malformed sticks
        next_start = 1'b1;
        add_byte("A");
        add_byte(hhed_pkg::CH_LF);
        add_byte("x");
        // line end in the blanks after the first word
        next_start = 1'b1;
        add_byte(hhed_pkg::CH_SP);
        add_byte(hhed_pkg::CH_CR);
        // line end in the blanks after the second word
        next_start = 1'b1;
        add_byte("A");
        add_byte(hhed_pkg::CH_SP);
        add_byte("B");
        add_byte(hhed_pkg::CH_SP);
        add_byte(hhed_pkg::CH_LF);
        // blank inside the third word
        next_start = 1'b1;
        add_byte("A");
        add_byte(hhed_pkg::CH_SP);
        add_byte("B");
        add_byte(hhed_pkg::CH_SP);
        add_byte("C");
        add_byte(hhed_pkg::CH_TAB);
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= 1'b0;
            in_gap   <= 0;
            bytes_in <= 0;
        end
        else
        begin
            // accepted transfer: work out its status
            if (s_tvalid && s_tready)
            begin
                status_due_q.push_back(parse_byte(s_tdata, s_tuser));
                bytes_in <= bytes_in + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (in_gap > 0)
                begin
                    in_gap   <= in_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (req_bytes_q.size() != 0)
                begin
                    s_tdata  <= req_bytes_q[0].data;
                    s_tuser  <= req_bytes_q[0].start;
                    s_tvalid <= 1'b1;
                    void'(req_bytes_q.pop_front());
                    in_gap   <= (quiet || hold_off) ? 0 : pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // stretches with no idling on either side
    assign quiet = ((bytes_in / 250) % 4) == 3;

    // one long output stall while input keeps coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off    <= 1'b0;
            hold_done   <= 1'b0;
            hold_cycles <= 0;
        end
        else if (!hold_done && bytes_in >= HOLD_AT)
        begin
            hold_cycles <= hold_cycles + 1;
            hold_off    <= (hold_cycles != HOLD_LEN - 1);
            hold_done   <= (hold_cycles == HOLD_LEN - 1);
        end
    end

    // ------------------------------------------------------------------
    // output monitor and ready generation
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            out_stall <= 0;
            fail_cnt  <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (status_due_q.size() == 0)
                begin
                    if (fail_cnt < MAX_REPORT)
                        $display("%0t: status transfer with none due, actual %0d",
                                 $realtime, m_tdata);
                    fail_cnt <= fail_cnt + 1;
                end
                else
                begin
                    if (m_tdata != {6'b0, status_due_q[0]})
                    begin
                        if (fail_cnt < MAX_REPORT)
                            $display("%0t: header_status mismatch, expected %0d actual %0d",
                                     $realtime, status_due_q[0], m_tdata);
                        fail_cnt <= fail_cnt + 1;
                    end
                    void'(status_due_q.pop_front());
                end
            end
            if (hold_off)
                m_tready <= 1'b0;
            else if (out_stall > 0)
            begin
                out_stall <= out_stall - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 99) < 30)
                    out_stall <= pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == MAX_CYCLES)
        begin
            $display("http_header_end_detector_top_tb NOT OK");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        next_start = 1'b0;
        add_directed();
        while (req_bytes_q.size() < NUM_ITEMS)
        begin
            if ($urandom_range(0, 19) == 0)
                add_noise();
            else
                add_request();
        end
        @(posedge rst_n);
        while (req_bytes_q.size() != 0 || s_tvalid)
            @(posedge clk);
        while (status_due_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (fail_cnt == 0 && status_due_q.size() == 0)
            $display("http_header_end_detector_top_tb OK");
        else
            $display("http_header_end_detector_top_tb NOT OK");
        $finish;
    end

endmodule
